/* rtl/xfr_pkg.sv */
// Package for the XOR frame response receiver.
// Holds the delimiter, the result kind codes and the result record type.
// No dependencies.
`default_nettype none

package xfr_pkg;

	localparam logic [7:0] DELIM = 8'hF5;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] answer_high;
		logic [7:0] answer_low;
		logic [7:0] answer_status;
		logic [7:0] data_byte;
		logic       start_bad;
		logic       end_bad;
		logic       checksum_bad;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

/* rtl/xor_frame_response_receiver.sv */
// Receiver for 0xF5-delimited, XOR-checksummed response frames, one byte per item.
// Depends on xfr_pkg for the delimiter, the kind codes and the result record.
//
// Usage:
// The slave channel takes one received byte per item in s_axis_tdata; s_axis_tuser
// carries the expect-data flag, which is only looked at with the first header byte.
// The master channel gives zero or one result per input item: a header result after
// the eighth header byte, one payload result per payload byte, and a status result
// after the closing byte of a data frame. m_axis_tuser holds the result kind and
// m_axis_tlast marks the final result of a response.
// An accepted byte passes through the input register, then through the frame logic
// into the result register, before its result appears on the master channel.
// Throughput is one item per cycle while the master channel does not stall, set by
// the single pass of the frame logic between those two registers.
// When the receiver stalls, the result register holds its item, the input register
// keeps the next byte, and s_axis_tready drops once both are full.
// Reset clears both valid bits and puts the frame logic back to waiting for a
// header, with all counters, checksum and stored header bytes at zero.
// Framing is by byte count alone; bad delimiters are only flagged.
`default_nettype none

module xor_frame_response_receiver (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire  [7:0]        s_axis_tdata,   // [7:0] rx_byte
	input  wire               s_axis_tuser,   // [0] expect_data
	output logic              m_axis_tvalid,
	input  wire               m_axis_tready,
	// [7:0] answer_high, [15:8] answer_low, [23:16] answer_status, [31:24] data_byte,
	// [32] start_bad, [33] end_bad, [34] checksum_bad, [39:35] zero
	output logic [39:0]       m_axis_tdata,
	output logic [1:0]        m_axis_tuser,   // [1:0] kind
	output logic              m_axis_tlast
);
	import xfr_pkg::*;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        ed_s1;
	logic        advance;

	logic [1:0]  phase_q, phase_d;
	logic [16:0] pos_q, pos_d;
	logic [7:0]  xor_q, xor_d;
	logic [7:0]  hdr_q [3];
	logic [7:0]  hdr_d [3];
	logic [15:0] len_q, len_d;
	logic        start_flag_q, start_flag_d;
	logic        data_exp_q, data_exp_d;

	logic        emit;
	result_t     res;
	logic        out_valid_q;
	result_t     out_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			ed_s1   <= s_axis_tuser;
		end
	end

	always_comb begin
		logic [16:0] len_ext;
		phase_d      = phase_q;
		pos_d        = pos_q;
		xor_d        = xor_q;
		hdr_d        = hdr_q;
		len_d        = len_q;
		start_flag_d = start_flag_q;
		data_exp_d   = data_exp_q;
		emit         = 1'b0;
		len_ext      = {1'b0, len_q};
		case (phase_q)
			PH_HEADER: begin
				if (pos_q[2:0] >= 3'd2 && pos_q[2:0] <= 3'd4) begin
					hdr_d[pos_q[1:0] - 2'd2] = byte_s1;
				end
				if (pos_q[2:0] != 3'd7) begin
					xor_d = xor_q ^ byte_s1;
					pos_d = {14'd0, pos_q[2:0]} + 17'd1;
				end else begin
					emit  = 1'b1;
					pos_d = '0;
					if (data_exp_q) begin
						len_d   = {hdr_q[0], hdr_q[1]};
						phase_d = PH_DATA;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			PH_DATA: begin
				if (pos_q == '0) begin
					start_flag_d = (byte_s1 != DELIM);
					xor_d        = byte_s1;
					pos_d        = 17'd1;
				end else if (pos_q <= len_ext) begin
					xor_d = xor_q ^ byte_s1;
					pos_d = pos_q + 17'd1;
					emit  = 1'b1;
				end else if (pos_q == len_ext + 17'd1) begin
					xor_d = xor_q ^ byte_s1;
					pos_d = pos_q + 17'd1;
				end else begin
					emit    = 1'b1;
					phase_d = PH_IDLE;
					pos_d   = '0;
				end
			end
			default: begin
				start_flag_d = (byte_s1 != DELIM);
				xor_d        = byte_s1;
				data_exp_d   = ed_s1;
				pos_d        = 17'd1;
				phase_d      = PH_HEADER;
			end
		endcase
	end

	always_comb begin
		res.answer_high   = hdr_d[0];
		res.answer_low    = hdr_d[1];
		res.answer_status = hdr_d[2];
		res.kind          = KIND_HEADER;
		res.data_byte     = 8'd0;
		res.start_bad     = start_flag_q;
		res.end_bad       = (byte_s1 != DELIM);
		res.checksum_bad  = (xor_q != 8'd0);
		res.last          = !data_exp_q;
		if (phase_q == PH_DATA) begin
			if (pos_q <= {1'b0, len_q}) begin
				res.kind         = KIND_PAYLOAD;
				res.data_byte    = byte_s1;
				res.start_bad    = 1'b0;
				res.end_bad      = 1'b0;
				res.checksum_bad = 1'b0;
				res.last         = 1'b0;
			end else begin
				res.kind = KIND_STATUS;
				res.last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			pos_q        <= '0;
			xor_q        <= '0;
			hdr_q        <= '{default: 8'd0};
			len_q        <= '0;
			start_flag_q <= 1'b0;
			data_exp_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				phase_q      <= phase_d;
				pos_q        <= pos_d;
				xor_q        <= xor_d;
				hdr_q        <= hdr_d;
				len_q        <= len_d;
				start_flag_q <= start_flag_d;
				data_exp_q   <= data_exp_d;
				out_valid_q  <= emit;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last;
	assign m_axis_tdata  = {5'd0, out_q.checksum_bad, out_q.end_bad, out_q.start_bad,
		out_q.data_byte, out_q.answer_status, out_q.answer_low, out_q.answer_high};

	a_header_pos_small: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> pos_q[16:3] == 14'd0)
		else $error("header byte position left the eight-byte frame");

	a_header_ends: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == PH_HEADER && pos_q[2:0] == 3'd7 |=>
		m_axis_tvalid && m_axis_tuser == KIND_HEADER && phase_q != PH_HEADER)
		else $error("eighth header byte did not close the header");

	a_data_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> pos_q <= {1'b0, len_q} + 17'd2)
		else $error("data frame position ran past the frame end");

	a_status_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && phase_q == PH_DATA && pos_q > {1'b0, len_q} |=>
		phase_q == PH_IDLE && m_axis_tlast)
		else $error("status result did not end the response");

endmodule

`default_nettype wire
